### hw/rtl/spe_pkg.sv
`default_nettype none

package spe_pkg;

    localparam int CNT_W       = 17;
    localparam int RATE_W      = 19;
    localparam int RATE_FRAC   = 16;
    localparam int GAIN_W      = 17;
    localparam int SMP_W       = 16;
    localparam int ADDR_W      = 16;
    localparam int MODE_W      = 3;
    localparam int CMD_W       = 3;
    localparam int XW          = CNT_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int REGIDX_W    = 2;

    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PLAY_ON  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PLAY_OFF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 3'd5;

    localparam logic [CMD_W-1:0] CMD_NOP      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PLAY_ON  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PLAY_OFF = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 3'd6;

    localparam logic [REGIDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_RATE         = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_GAIN         = 2'd2;
    localparam logic [REGIDX_W-1:0] REG_ONESHOT      = 2'd3;

    localparam logic [CNT_W-1:0]  RST_SAMPLE_COUNT = 17'd0;
    localparam logic [RATE_W-1:0] RST_RATE         = 19'h10000;
    localparam logic [GAIN_W-1:0] RST_GAIN         = 17'd39322;
    localparam logic [GAIN_W-1:0] GAIN_UNITY       = 17'd65536;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [SMP_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              rate_neg;
        logic [RATE_W-1:0] rate_mag;
        logic [GAIN_W-1:0] gain;
        logic              oneshot;
    } cfg_t;

    // Remainder of x by c for x below five times c.
    function automatic logic [XW-1:0] mod_small(input logic [XW-1:0] x,
                                                input logic [CNT_W-1:0] c);
        logic [XW+2:0] xw;
        logic [XW+2:0] c1;
        logic [XW+2:0] c2;
        logic [XW+2:0] c3;
        logic [XW+2:0] c4;
        logic [XW+2:0] r;
        xw = (XW+3)'(x);
        c1 = (XW+3)'(c);
        c2 = c1 << 1;
        c3 = c2 + c1;
        c4 = c1 << 2;
        if (xw < c1)
        begin
            r = xw;
        end
        else if (xw < c2)
        begin
            r = xw - c1;
        end
        else if (xw < c3)
        begin
            r = xw - c2;
        end
        else if (xw < c4)
        begin
            r = xw - c3;
        end
        else
        begin
            r = xw - c4;
        end
        return r[XW-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/spe_regs.sv
`default_nettype none

module spe_regs
    import spe_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 65536
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    localparam int CAP_INT = (SAMPLE_DEPTH < (1 << CNT_W)) ? SAMPLE_DEPTH : (1 << CNT_W) - 1;
    localparam logic [CNT_W:0] COUNT_CAP = (CNT_W+1)'(CAP_INT);

    logic [CNT_W-1:0]    count_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic                oneshot_reg;
    logic                wr_en;
    logic [REGIDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= RST_SAMPLE_COUNT;
            rate_reg    <= RST_RATE;
            gain_reg    <= RST_GAIN;
            oneshot_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SAMPLE_COUNT: count_reg   <= pwdata[CNT_W-1:0];
                REG_RATE:         rate_reg    <= pwdata[RATE_W-1:0];
                REG_GAIN:         gain_reg    <= pwdata[GAIN_W-1:0];
                REG_ONESHOT:      oneshot_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SAMPLE_COUNT: prdata = PDATA_W'(count_reg);
            REG_RATE:         prdata = {{(PDATA_W-RATE_W){rate_reg[RATE_W-1]}}, rate_reg};
            REG_GAIN:         prdata = PDATA_W'(gain_reg);
            REG_ONESHOT:      prdata = PDATA_W'(oneshot_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.count    = ({1'b0, count_reg} > COUNT_CAP) ? COUNT_CAP[CNT_W-1:0] : count_reg;
        cfg.rate_neg = rate_reg[RATE_W-1];
        cfg.rate_mag = rate_reg[RATE_W-1] ? (~rate_reg + RATE_W'(1)) : rate_reg;
        cfg.gain     = (gain_reg > GAIN_UNITY) ? GAIN_UNITY : gain_reg;
        cfg.oneshot  = oneshot_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/spe_front.sv
`default_nettype none

module spe_front
    import spe_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 65536
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic        [MODE_W-1:0] mode,
    input  wire logic        [ADDR_W-1:0] sample_addr,
    input  wire logic signed [SMP_W-1:0]  sample_value,
    output logic                          head_valid,
    output item_t                         head,
    input  wire logic                     pop
);

    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              do_pop;
    logic              in_range;
    item_t             decoded;

    assign in_range = (32'(sample_addr) < SAMPLE_DEPTH);

    always_comb
    begin
        decoded.addr  = sample_addr;
        decoded.value = sample_value;
        unique case (mode)
            MODE_TICK:     decoded.cmd = CMD_TICK;
            MODE_LOAD:     decoded.cmd = in_range ? CMD_LOAD : CMD_NOP;
            MODE_PLAY_ON:  decoded.cmd = CMD_PLAY_ON;
            MODE_PLAY_OFF: decoded.cmd = CMD_PLAY_OFF;
            MODE_NOTE_ON:  decoded.cmd = CMD_NOTE_ON;
            MODE_NOTE_OFF: decoded.cmd = CMD_NOTE_OFF;
            default:       decoded.cmd = CMD_NOP;
        endcase
    end

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid & ~item_stall;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop & head_valid;
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push & ~do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop & ~push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/spe_back.sv
`default_nettype none

module spe_back
    import spe_pkg::*;
#(
    parameter int SAMPLE_DEPTH  = 65536,
    parameter int POS_FRAC_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cfg_t                    cfg,
    input  wire logic                    head_valid,
    input  wire item_t                   head,
    output logic                         pop,
    output logic signed [SMP_W-1:0]      audio_out,
    output logic                         active,
    output logic                         result_valid,
    input  wire logic                    result_stall
);

    localparam int F  = POS_FRAC_BITS;
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int IW = (SAMPLE_DEPTH > (1 << CNT_W)) ? CNT_W : AW;
    localparam int PW = IW + F;
    localparam int FW = XW + F;
    localparam int PROD_W = SMP_W + GAIN_W + 1;

    logic [SMP_W-1:0] mem [SAMPLE_DEPTH];

    logic [PW-1:0]    pos_reg;
    logic [PW-1:0]    pos_next;
    logic [CNT_W-1:0] rel_reg;
    logic [CNT_W-1:0] rel_next;
    logic             playing_reg;
    logic             playing_next;
    logic             released_reg;
    logic             released_next;

    logic                     s1_valid_reg;
    logic                     s1_act_reg;
    logic signed [SMP_W-1:0]  ram_q_reg;
    logic                     s2_valid_reg;
    logic                     s2_act_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     result_valid_reg;
    logic                     active_reg;
    logic signed [SMP_W-1:0]  audio_reg;

    logic                     adv;
    logic                     exec;
    logic                     sounding;
    logic [XW-1:0]            cnt_x;
    logic [XW-1:0]            last_x;
    logic [FW-1:0]            end_full;
    logic [FW-1:0]            p;
    logic [FW-1:0]            mag_full;
    logic [FW-1:0]            fsum;
    logic [XW-1:0]            fint_mod;
    logic [FW-1:0]            fwd_pos;
    logic [FW-1:0]            rdiff;
    logic [FW-1:0]            dmag;
    logic [XW-1:0]            rint_mod;
    logic [FW-1:0]            r_full;
    logic [FW-1:0]            rev_pos;
    logic [FW-1:0]            new_pos;
    logic [AW-1:0]            raddr;
    logic [AW-1:0]            waddr;
    logic                     we;
    logic signed [PROD_W-1:0] mult;
    logic signed [PROD_W-1:0] rnd;

    assign adv  = ~result_valid_reg | ~result_stall;
    assign pop  = head_valid & adv;
    assign exec = pop;

    assign cnt_x    = XW'(cfg.count);
    assign last_x   = cnt_x - XW'(1);
    assign end_full = FW'(cnt_x) << F;
    assign sounding = playing_reg & (cfg.count != '0) & (rel_reg != '0);

    // A position left beyond a shrunken sample count restarts at zero.
    assign p = (XW'(pos_reg[PW-1:F]) >= cnt_x) ? '0 : FW'(pos_reg);

    generate
        if (F >= RATE_FRAC)
        begin : g_mag_up
            assign mag_full = FW'(cfg.rate_mag) << (F - RATE_FRAC);
        end
        else
        begin : g_mag_down
            assign mag_full = FW'(cfg.rate_mag >> (RATE_FRAC - F));
        end
    endgenerate

    assign fsum     = p + mag_full;
    assign fint_mod = mod_small(fsum[FW-1:F], cfg.count);
    assign fwd_pos  = (p[FW-1:F] < last_x) ? {fint_mod, fsum[F-1:0]} : '0;

    assign rdiff    = p - mag_full;
    assign dmag     = mag_full - p;
    assign rint_mod = mod_small(dmag[FW-1:F], cfg.count);
    assign r_full   = {rint_mod, dmag[F-1:0]};

    always_comb
    begin
        if (p == '0)
        begin
            rev_pos = {last_x, {F{1'b0}}};
        end
        else if (mag_full <= p)
        begin
            rev_pos = rdiff;
        end
        else if (r_full == '0)
        begin
            rev_pos = '0;
        end
        else
        begin
            rev_pos = end_full - r_full;
        end
    end

    assign new_pos = cfg.rate_neg ? rev_pos : fwd_pos;
    assign raddr   = AW'(p[FW-1:F]);
    assign waddr   = AW'(head.addr);
    assign we      = exec & (head.cmd == CMD_LOAD);

    always_comb
    begin
        pos_next      = pos_reg;
        rel_next      = rel_reg;
        playing_next  = playing_reg;
        released_next = released_reg;
        if (exec)
        begin
            unique case (head.cmd)
                CMD_TICK:
                begin
                    if (sounding)
                    begin
                        pos_next = PW'(new_pos);
                        if (released_reg | cfg.oneshot)
                        begin
                            rel_next = rel_reg - CNT_W'(1);
                        end
                    end
                end
                CMD_PLAY_ON:
                begin
                    playing_next = 1'b1;
                    rel_next     = cfg.count;
                    pos_next     = '0;
                end
                CMD_NOTE_ON:
                begin
                    playing_next  = 1'b1;
                    rel_next      = cfg.count;
                    pos_next      = '0;
                    released_next = 1'b0;
                end
                CMD_PLAY_OFF:
                begin
                    playing_next = 1'b0;
                end
                CMD_NOTE_OFF:
                begin
                    released_next = 1'b1;
                    if (!cfg.oneshot)
                    begin
                        rel_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            rel_reg          <= '0;
            playing_reg      <= 1'b0;
            released_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_act_reg       <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s2_act_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            active_reg       <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            rel_reg      <= rel_next;
            playing_reg  <= playing_next;
            released_reg <= released_next;
            if (adv)
            begin
                s1_valid_reg     <= exec;
                s1_act_reg       <= exec & (head.cmd == CMD_TICK) & sounding;
                s2_valid_reg     <= s1_valid_reg;
                s2_act_reg       <= s1_act_reg;
                result_valid_reg <= s2_valid_reg;
                active_reg       <= s2_act_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (we)
            begin
                mem[waddr] <= head.value;
            end
            ram_q_reg <= mem[raddr];
        end
    end

    assign mult = ram_q_reg * $signed({1'b0, cfg.gain});
    assign rnd  = prod_reg + PROD_W'(32768);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= s1_act_reg ? mult : '0;
            audio_reg <= rnd[31:16];
        end
    end

    assign audio_out    = audio_reg;
    assign active       = active_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

### hw/rtl/sample_playback_engine_top.sv
`default_nettype none

// Each accepted request passes through the RAM read, product and output registers before its result appears.
// Throughput: one request per cycle while results are not stalled; the position update is combinational.
// A four-entry queue separates decode from execution so either side may stall.
// Reset is asynchronous and active low; it clears playback state and registers.
// The sample memory is not cleared and holds unknown data until loaded.
module sample_playback_engine_top
    import spe_pkg::*;
#(
    parameter int SAMPLE_DEPTH  = 65536,
    parameter int POS_FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic        [MODE_W-1:0] mode,
    input  wire logic        [ADDR_W-1:0] sample_addr,
    input  wire logic signed [SMP_W-1:0]  sample_value,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic signed      [SMP_W-1:0]  audio_out,
    output logic                          active,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic        [PADDR_W-1:0] paddr,
    input  wire logic        [PDATA_W-1:0] pwdata,
    output logic             [PDATA_W-1:0] prdata,
    output logic                          pready
);

    cfg_t  cfg;
    item_t head;
    logic  head_valid;
    logic  pop;

    spe_regs #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spe_front #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .sample_addr  (sample_addr),
        .sample_value (sample_value),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    spe_back #(
        .SAMPLE_DEPTH  (SAMPLE_DEPTH),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .audio_out    (audio_out),
        .active       (active),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // A result that did not sound must be silent.
    a_silent_when_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !active |-> audio_out == '0)
        else $error("inactive result carries a nonzero sample");

    a_stall_means_queued: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> head_valid)
        else $error("input stalled while the queue is empty");

    a_accept_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> head_valid)
        else $error("accepted request did not reach the queue");

endmodule

`default_nettype wire
